// ===== rtl/core/bmprle_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types for the RLE decoder.
package bmprle_pkg;

	// Default pixel counter width
	localparam int PIXEL_COUNT_BITS = 24;

	// Configuration data width (widest register) and payload widths
	localparam int CFG_DATA_W = 24;
	localparam int PIX_W      = 8;
	localparam int CNT_W      = 3;
	localparam int LANES      = 4;

	// Configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_RLE_MODE    = 1'b0;
	localparam cfg_idx_t REG_PIXEL_TOTAL = 1'b1;

	// Datapath operations issued by the controller
	typedef logic [3:0] dp_op_t;
	localparam dp_op_t OP_NONE        = 4'd0;
	localparam dp_op_t OP_LOAD        = 4'd1;
	localparam dp_op_t OP_SET_COUNT   = 4'd2;
	localparam dp_op_t OP_START_ABS   = 4'd3;
	localparam dp_op_t OP_START_DELTA = 4'd4;
	localparam dp_op_t OP_STEP_DELTA  = 4'd5;
	localparam dp_op_t OP_EMIT_ABS    = 4'd6;
	localparam dp_op_t OP_EMIT_RUN    = 4'd7;
	localparam dp_op_t OP_MARKER      = 4'd8;

	// Controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   clear;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic byte_is0;
		logic byte_is1;
		logic byte_is2;
		logic run_nz;
		logic at_total;
		logic delta_last;
		logic abs_finish;
		logic abs_end;
		logic run_finish;
		logic run_end;
		logic pad_pending;
	} dp_status_t;

endpackage

// ===== rtl/core/bmprle_dp.sv =====
// Datapath: configuration, decode counters, pixel group builder and output register.
module bmprle_dp #(
	parameter int PIXEL_COUNT_BITS = bmprle_pkg::PIXEL_COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  bmprle_pkg::cfg_idx_t              cfg_index,
	input  logic [bmprle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [7:0]                        stream_byte,
	input  bmprle_pkg::dp_cmd_t               cmd,
	output bmprle_pkg::dp_status_t            status,
	output logic [7:0]                        pixel_a,
	output logic [7:0]                        pixel_b,
	output logic [7:0]                        pixel_c,
	output logic [7:0]                        pixel_d,
	output logic [2:0]                        pixel_valid_count,
	output logic                              last_of_run,
	output logic                              image_done
);

	localparam int PW = PIXEL_COUNT_BITS;
	localparam int CW = bmprle_pkg::CFG_DATA_W;

	logic                mode_q;
	logic [CW-1:0]       total_q;
	logic [7:0]          byte_q;
	logic [7:0]          run_length_q;
	logic [7:0]          absolute_left_q;
	logic                pad_pending_q;
	logic [1:0]          delta_left_q;
	logic [PW-1:0]       emitted_q;

	logic [7:0]          lane_q [bmprle_pkg::LANES];
	logic [2:0]          count_q;
	logic                last_q;
	logic                done_q;

	logic [PW-1:0]       total_m;
	logic [PW-1:0]       remaining;
	logic [2:0]          cap_run;
	logic [2:0]          cap_abs;
	logic [2:0]          n_run;
	logic [2:0]          n_abs;
	logic [2:0]          n_emit;
	logic                run_finish;
	logic                abs_finish;
	logic                run_end;
	logic [7:0]          gray_hi;
	logic [7:0]          gray_lo;
	logic [8:0]          byte_inc;
	logic                pad_new;
	logic [7:0]          lane_d [bmprle_pkg::LANES];
	logic                emit_grp;

	// Fit the total register to the counter width
	generate
		if (PW > CW) begin : g_total_wide
			assign total_m = {{(PW - CW){1'b0}}, total_q};
		end else if (PW == CW) begin : g_total_same
			assign total_m = total_q;
		end else begin : g_total_narrow
			assign total_m = total_q[PW-1:0];
		end
	endgenerate

	// Pixels still allowed before the total is reached
	assign remaining = total_m - emitted_q;

	// Group size for a run and for absolute data, cut at the total
	assign cap_run    = (run_length_q >= 8'd4) ? 3'd4 : run_length_q[2:0];
	assign cap_abs    = (mode_q && (absolute_left_q >= 8'd2)) ? 3'd2 : 3'd1;
	assign run_finish = {{(PW - 3){1'b0}}, cap_run} >= remaining;
	assign abs_finish = {{(PW - 3){1'b0}}, cap_abs} >= remaining;
	assign run_end    = run_length_q <= 8'd4;
	assign n_run      = run_finish ? remaining[2:0] : cap_run;
	assign n_abs      = abs_finish ? remaining[2:0] : cap_abs;
	assign n_emit     = (cmd.op == bmprle_pkg::OP_EMIT_RUN) ? n_run : n_abs;
	assign emit_grp   = (cmd.op == bmprle_pkg::OP_EMIT_RUN) ||
	                    (cmd.op == bmprle_pkg::OP_EMIT_ABS);

	// Nibble to gray: value times sixteen
	assign gray_hi = {byte_q[7:4], 4'h0};
	assign gray_lo = {byte_q[3:0], 4'h0};

	// Pad byte follows an odd byte count of absolute data
	assign byte_inc = {1'b0, byte_q} + 9'd1;
	assign pad_new  = mode_q ? byte_inc[1] : byte_q[0];

	// Build the lanes; lanes past the count read zero
	always_comb begin
		for (int j = 0; j < bmprle_pkg::LANES; j++) begin
			if (3'(j) >= n_emit) begin
				lane_d[j] = 8'd0;
			end else if (mode_q) begin
				lane_d[j] = (j % 2 == 1) ? gray_lo : gray_hi;
			end else begin
				lane_d[j] = byte_q;
			end
		end
	end

	// Status toward the controller
	always_comb begin
		status.byte_is0    = byte_q == 8'd0;
		status.byte_is1    = byte_q == 8'd1;
		status.byte_is2    = byte_q == 8'd2;
		status.run_nz      = run_length_q != 8'd0;
		status.at_total    = emitted_q >= total_m;
		status.delta_last  = delta_left_q <= 2'd1;
		status.abs_finish  = abs_finish;
		status.abs_end     = absolute_left_q <= {5'd0, cap_abs};
		status.run_finish  = run_finish;
		status.run_end     = run_end;
		status.pad_pending = pad_pending_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			total_q <= CW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmprle_pkg::REG_RLE_MODE:    mode_q  <= cfg_data[0];
				bmprle_pkg::REG_PIXEL_TOTAL: total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode state; a new frame clears it as its first byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q    <= 8'd0;
			absolute_left_q <= 8'd0;
			pad_pending_q   <= 1'b0;
			delta_left_q    <= 2'd0;
			emitted_q       <= '0;
		end else if (cmd.clear) begin
			run_length_q    <= 8'd0;
			absolute_left_q <= 8'd0;
			pad_pending_q   <= 1'b0;
			delta_left_q    <= 2'd0;
			emitted_q       <= '0;
		end else begin
			unique case (cmd.op)
				bmprle_pkg::OP_SET_COUNT: run_length_q <= byte_q;
				bmprle_pkg::OP_START_ABS: begin
					absolute_left_q <= byte_q;
					pad_pending_q   <= pad_new;
				end
				bmprle_pkg::OP_START_DELTA: delta_left_q <= 2'd2;
				bmprle_pkg::OP_STEP_DELTA:  delta_left_q <= delta_left_q - 2'd1;
				bmprle_pkg::OP_EMIT_ABS: begin
					absolute_left_q <= absolute_left_q - {5'd0, cap_abs};
					emitted_q       <= emitted_q + {{(PW - 3){1'b0}}, n_abs};
				end
				bmprle_pkg::OP_EMIT_RUN: begin
					run_length_q <= run_length_q - {5'd0, n_run};
					emitted_q    <= emitted_q + {{(PW - 3){1'b0}}, n_run};
				end
				default: ;
			endcase
		end
	end

	// Hold the byte under decode
	always_ff @(posedge clk) begin
		if (cmd.op == bmprle_pkg::OP_LOAD) begin
			byte_q <= stream_byte;
		end
	end

	// Output register: a pixel group or a bare done marker
	always_ff @(posedge clk) begin
		if (emit_grp) begin
			for (int j = 0; j < bmprle_pkg::LANES; j++) begin
				lane_q[j] <= lane_d[j];
			end
			count_q <= n_emit;
			if (cmd.op == bmprle_pkg::OP_EMIT_RUN) begin
				last_q <= run_finish || run_end;
				done_q <= run_finish;
			end else begin
				last_q <= 1'b1;
				done_q <= abs_finish;
			end
		end else if (cmd.op == bmprle_pkg::OP_MARKER) begin
			for (int j = 0; j < bmprle_pkg::LANES; j++) begin
				lane_q[j] <= 8'd0;
			end
			count_q <= 3'd0;
			last_q  <= 1'b1;
			done_q  <= 1'b1;
		end
	end

	assign pixel_a           = lane_q[0];
	assign pixel_b           = lane_q[1];
	assign pixel_c           = lane_q[2];
	assign pixel_d           = lane_q[3];
	assign pixel_valid_count = count_q;
	assign last_of_run       = last_q;
	assign image_done        = done_q;

endmodule

// ===== rtl/core/bmprle_ctrl.sv =====
// Controller: request handshakes, stream phase tracking and datapath sequencing.
module bmprle_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   frame_start,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  bmprle_pkg::dp_status_t status,
	output bmprle_pkg::dp_cmd_t    cmd
);

	// Sequencer states
	localparam logic [1:0] SEQ_IDLE   = 2'd0;
	localparam logic [1:0] SEQ_DECODE = 2'd1;
	localparam logic [1:0] SEQ_EMIT   = 2'd2;

	// Stream phases
	localparam logic [2:0] PH_COUNT = 3'd0;
	localparam logic [2:0] PH_CMD   = 3'd1;
	localparam logic [2:0] PH_ABS   = 3'd2;
	localparam logic [2:0] PH_PAD   = 3'd3;
	localparam logic [2:0] PH_DELTA = 3'd4;
	localparam logic [2:0] PH_DONE  = 3'd5;

	logic [1:0] seq_q, seq_d;
	logic [2:0] phase_q, phase_d;
	logic [2:0] phase_n;
	logic       out_valid_q;
	logic       out_free;
	logic       emit;

	assign out_free = !out_valid_q || out_ready;

	// Next state and datapath command
	always_comb begin
		seq_d     = seq_q;
		phase_d   = phase_q;
		cmd.op    = bmprle_pkg::OP_NONE;
		cmd.clear = 1'b0;
		unique case (seq_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					cmd.op    = bmprle_pkg::OP_LOAD;
					cmd.clear = frame_start;
					seq_d     = SEQ_DECODE;
					if (frame_start) begin
						phase_d = PH_COUNT;
					end
				end
			end
			SEQ_DECODE: begin
				if (phase_q >= PH_DONE) begin
					// drop bytes after the image has finished
					seq_d = SEQ_IDLE;
				end else if (status.at_total) begin
					if (out_free) begin
						cmd.op  = bmprle_pkg::OP_MARKER;
						phase_d = PH_DONE;
						seq_d   = SEQ_IDLE;
					end
				end else begin
					unique case (phase_q)
						PH_COUNT: begin
							cmd.op  = bmprle_pkg::OP_SET_COUNT;
							phase_d = PH_CMD;
							seq_d   = SEQ_IDLE;
						end
						PH_CMD: begin
							if (status.run_nz) begin
								phase_d = PH_COUNT;
								seq_d   = SEQ_EMIT;
							end else if (status.byte_is0) begin
								// end of line is skipped
								phase_d = PH_COUNT;
								seq_d   = SEQ_IDLE;
							end else if (status.byte_is1) begin
								if (out_free) begin
									cmd.op  = bmprle_pkg::OP_MARKER;
									phase_d = PH_DONE;
									seq_d   = SEQ_IDLE;
								end
							end else if (status.byte_is2) begin
								cmd.op  = bmprle_pkg::OP_START_DELTA;
								phase_d = PH_DELTA;
								seq_d   = SEQ_IDLE;
							end else begin
								cmd.op  = bmprle_pkg::OP_START_ABS;
								phase_d = PH_ABS;
								seq_d   = SEQ_IDLE;
							end
						end
						PH_ABS: begin
							if (out_free) begin
								cmd.op = bmprle_pkg::OP_EMIT_ABS;
								seq_d  = SEQ_IDLE;
								if (status.abs_finish) begin
									phase_d = PH_DONE;
								end else if (status.abs_end) begin
									phase_d = PH_PAD;
								end
							end
						end
						PH_PAD: begin
							phase_d = PH_COUNT;
							seq_d   = SEQ_IDLE;
						end
						PH_DELTA: begin
							if (!status.delta_last) begin
								cmd.op = bmprle_pkg::OP_STEP_DELTA;
								seq_d  = SEQ_IDLE;
							end else if (out_free) begin
								cmd.op  = bmprle_pkg::OP_MARKER;
								phase_d = PH_DONE;
								seq_d   = SEQ_IDLE;
							end
						end
						default: seq_d = SEQ_IDLE;
					endcase
				end
			end
			SEQ_EMIT: begin
				if (out_free) begin
					cmd.op = bmprle_pkg::OP_EMIT_RUN;
					if (status.run_finish) begin
						phase_d = PH_DONE;
						seq_d   = SEQ_IDLE;
					end else if (status.run_end) begin
						seq_d = SEQ_IDLE;
					end
				end
			end
			default: seq_d = SEQ_IDLE;
		endcase
	end

	// Pad phase is only entered when a pad byte is owed
	always_comb begin
		phase_n = phase_d;
		if (phase_d == PH_PAD && !status.pad_pending) begin
			phase_n = PH_COUNT;
		end
	end

	assign emit = (cmd.op == bmprle_pkg::OP_EMIT_ABS) ||
	              (cmd.op == bmprle_pkg::OP_EMIT_RUN) ||
	              (cmd.op == bmprle_pkg::OP_MARKER);

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SEQ_IDLE;
			phase_q     <= PH_COUNT;
			out_valid_q <= 1'b0;
		end else begin
			seq_q       <= seq_d;
			phase_q     <= phase_n;
			out_valid_q <= emit || (out_valid_q && !out_ready);
		end
	end

	assign in_ready  = seq_q == SEQ_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/bmp_rle_pixel_decoder.sv =====
// Top level of the bitmap RLE8/RLE4 pixel decoder.
//
// Input channel (in_valid/in_ready): one compressed byte per request, with
// frame_start set on the first byte of an image to clear the decode state.
// Output channel (out_valid/out_ready): groups of up to four gray pixels,
// pixel_valid_count giving how many lanes hold pixels (0 for a bare done
// marker), last_of_run on the final group caused by a byte and image_done
// once the pixel total, an end-of-bitmap or a delta has finished the image.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 mode,
// 1 pixel total); write only while the decoder is idle.
// Sequencing: a byte is taken while idle and decoded in the next cycle. A
// single group or done marker is loaded into the output register at the
// end of the decode cycle. A run is drained by the controller one group per
// cycle while the output register is free, and in_ready returns after the
// last group of the run is loaded.
// Reset: arst_n clears the controller, the decode state and the registers
// (8-bit mode, total of one pixel). When the receiver stalls, the held
// group stays put and the decoder waits before loading the next group.
module bmp_rle_pixel_decoder #(
	parameter int PIXEL_COUNT_BITS = bmprle_pkg::PIXEL_COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  bmprle_pkg::cfg_idx_t              cfg_index,
	input  logic [bmprle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        stream_byte,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        pixel_a,
	output logic [7:0]                        pixel_b,
	output logic [7:0]                        pixel_c,
	output logic [7:0]                        pixel_d,
	output logic [2:0]                        pixel_valid_count,
	output logic                              last_of_run,
	output logic                              image_done
);

	bmprle_pkg::dp_cmd_t    cmd;
	bmprle_pkg::dp_status_t status;

	bmprle_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.frame_start (frame_start),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.cmd         (cmd)
	);

	bmprle_dp #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.stream_byte       (stream_byte),
		.cmd               (cmd),
		.status            (status),
		.pixel_a           (pixel_a),
		.pixel_b           (pixel_b),
		.pixel_c           (pixel_c),
		.pixel_d           (pixel_d),
		.pixel_valid_count (pixel_valid_count),
		.last_of_run       (last_of_run),
		.image_done        (image_done)
	);

endmodule

// ===== rtl/core/bmprle_chk.sv =====
// Port-level assertions for the RLE decoder and the bind that attaches them.
module bmprle_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pixel_a,
	input logic [7:0] pixel_b,
	input logic [7:0] pixel_c,
	input logic [7:0] pixel_d,
	input logic [2:0] pixel_valid_count,
	input logic       last_of_run,
	input logic       image_done
);

	// Hold a stalled request
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_a) && $stable(pixel_d) &&
		$stable(pixel_valid_count) && $stable(last_of_run) && $stable(image_done))
		else $error("output request changed while stalled");

	// A group never holds more than four pixels
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_valid_count <= 3'd4)
		else $error("pixel count above four");

	// A bare marker only closes a finished image
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid_count == 3'd0 |-> last_of_run && image_done)
		else $error("empty group that is not a done marker");

	// Done is only flagged on the last group of a byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> last_of_run)
		else $error("image done without last of run");

	// Lanes past the count read zero
	a_lane_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid_count < 3'd4 |->
		pixel_d == 8'd0 && (pixel_valid_count >= 3'd3 || pixel_c == 8'd0) &&
		(pixel_valid_count >= 3'd2 || pixel_b == 8'd0) &&
		(pixel_valid_count >= 3'd1 || pixel_a == 8'd0))
		else $error("lane beyond count is not zero");

endmodule

bind bmp_rle_pixel_decoder bmprle_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.pixel_a           (pixel_a),
	.pixel_b           (pixel_b),
	.pixel_c           (pixel_c),
	.pixel_d           (pixel_d),
	.pixel_valid_count (pixel_valid_count),
	.last_of_run       (last_of_run),
	.image_done        (image_done)
);
